FILE: hw/rtl/rrr_pkg.sv
// Shared types and codes for the resource reorder retirer.
// Used by rrr_ctrl, rrr_dp and resource_reorder_retirer_top; no dependencies.
package rrr_pkg;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_REQUEST = 2'd1;
    localparam logic [1:0] MODE_DONE    = 2'd2;

    localparam logic [2:0] STAT_GRANT      = 3'd0;
    localparam logic [2:0] STAT_RETIRE     = 3'd1;
    localparam logic [2:0] STAT_WAIT       = 3'd2;
    localparam logic [2:0] STAT_EXHAUSTED  = 3'd3;
    localparam logic [2:0] STAT_NONE_READY = 3'd4;
    localparam logic [2:0] STAT_REJECTED   = 3'd5;
    localparam logic [2:0] STAT_STARTED    = 3'd6;

    localparam logic REG_SEQ_TOTAL = 1'b0;
    localparam logic REG_RES_COUNT = 1'b1;

    localparam int MAX_OUT = 16;
    localparam int BURST_W = 5;

    typedef struct packed {
        logic       start;
        logic       fill;
        logic       pop;
        logic       grant;
        logic       mark;
        logic       slot_rd;
        logic       retire;
        logic       emit;
        logic [2:0] code;
    } cmd_t;

    typedef struct packed {
        logic fill_done;
        logic exhausted;
        logic empty;
        logic cmp_ok;
        logic can_retire;
        logic more;
        logic out_free;
    } sts_t;

endpackage

FILE: hw/rtl/rrr_ctrl.sv
// Controller FSM of the resource reorder retirer.
// Depends on rrr_pkg; drives rrr_dp through cmd_t, reads sts_t.
module rrr_ctrl
    import rrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] mode,
    input  sts_t       sts,
    output logic       in_ready,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_GRANT = 3'd2;
    localparam logic [2:0] ST_RCHK  = 3'd3;
    localparam logic [2:0] ST_RRD   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mode)
                        MODE_START:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_FILL;
                        end
                        MODE_REQUEST:
                        begin
                            if (sts.exhausted)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_EXHAUSTED;
                            end
                            else if (sts.empty)
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_WAIT;
                            end
                            else
                            begin
                                cmd.pop    = 1'b1;
                                state_next = ST_GRANT;
                            end
                        end
                        MODE_DONE:
                        begin
                            if (sts.cmp_ok)
                            begin
                                cmd.mark   = 1'b1;
                                state_next = ST_RCHK;
                            end
                            else
                            begin
                                cmd.emit = 1'b1;
                                cmd.code = STAT_REJECTED;
                            end
                        end
                        default:
                        begin
                            cmd.emit = 1'b1;
                            cmd.code = STAT_REJECTED;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (!sts.fill_done)
                begin
                    cmd.fill = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = STAT_STARTED;
                    state_next = ST_IDLE;
                end
            end
            ST_GRANT:
            begin
                if (sts.out_free)
                begin
                    cmd.grant  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RCHK:
            begin
                if (sts.can_retire)
                begin
                    cmd.slot_rd = 1'b1;
                    state_next  = ST_RRD;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = STAT_NONE_READY;
                    state_next = ST_IDLE;
                end
            end
            ST_RRD:
            begin
                if (sts.out_free)
                begin
                    cmd.retire = 1'b1;
                    if (!sts.more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/rrr_dp.sv
// Datapath of the resource reorder retirer: free stack, slot table, counters,
// result register. Depends on rrr_pkg; commanded by rrr_ctrl.
module rrr_dp
    import rrr_pkg::*;
#(
    parameter int MAX_RESOURCES = 16,
    parameter int SEQ_WIDTH     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [3:0]  done_resource,
    input  logic [31:0] done_sequence,
    input  logic [31:0] seq_total,
    input  logic [4:0]  res_count,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_status,
    output logic [3:0]  out_resource,
    output logic [31:0] out_sequence,
    output logic        out_last,
    output logic        out_all_done
);

    localparam int ID_W  = $clog2(MAX_RESOURCES);
    localparam int CNT_W = $clog2(MAX_RESOURCES + 1);

    logic [ID_W-1:0]      stack_mem [MAX_RESOURCES];
    logic [3:0]           slot_mem  [MAX_RESOURCES];

    logic [CNT_W-1:0]     free_top_reg,    free_top_next;
    logic [CNT_W-1:0]     fill_cnt_reg,    fill_cnt_next;
    logic [SEQ_WIDTH-1:0] issue_reg,       issue_next;
    logic [SEQ_WIDTH-1:0] retire_reg,      retire_next;
    logic [ID_W-1:0]      rslot_reg,       rslot_next;
    logic [MAX_RESOURCES-1:0] slot_done_reg, slot_done_next;
    logic [BURST_W-1:0]   burst_reg,       burst_next;
    logic [ID_W-1:0]      stack_rd_reg;
    logic [3:0]           slot_rd_reg;

    logic                 out_valid_reg,   out_valid_next;
    logic [2:0]           out_status_reg,  out_status_next;
    logic [3:0]           out_res_reg,     out_res_next;
    logic [31:0]          out_seq_reg,     out_seq_next;
    logic                 out_last_reg,    out_last_next;
    logic                 out_done_reg,    out_done_next;

    logic [SEQ_WIDTH-1:0] total;
    logic [SEQ_WIDTH-1:0] dseq;
    logic [SEQ_WIDTH-1:0] diff;
    logic [SEQ_WIDTH-1:0] retire_inc;
    logic [CNT_W-1:0]     clamp;
    logic [CNT_W-1:0]     top_m1;
    logic [ID_W:0]        slot_sum;
    logic [ID_W-1:0]      slot;
    logic [ID_W-1:0]      rslot_inc;
    logic                 in_window;
    logic                 push_ok;
    logic                 stack_we;
    logic [ID_W-1:0]      stack_wa;
    logic [ID_W-1:0]      stack_wd;
    logic                 slot_re;
    logic [ID_W-1:0]      slot_ra;

    assign total      = SEQ_WIDTH'(seq_total);
    assign dseq       = SEQ_WIDTH'(done_sequence);
    assign diff       = dseq - retire_reg;
    assign retire_inc = retire_reg + SEQ_WIDTH'(1);
    assign clamp      = (32'(res_count) > MAX_RESOURCES) ? CNT_W'(MAX_RESOURCES)
                                                        : CNT_W'(res_count);
    assign top_m1     = free_top_reg - CNT_W'(1);
    assign rslot_inc  = (32'(rslot_reg) == MAX_RESOURCES - 1) ? '0 : rslot_reg + ID_W'(1);

    // dseq is within MAX_RESOURCES of retire_reg when in window: one wrap at most
    assign slot_sum   = {1'b0, rslot_reg} + {1'b0, diff[ID_W-1:0]};
    assign slot       = (slot_sum >= (ID_W+1)'(MAX_RESOURCES))
                        ? ID_W'(slot_sum - (ID_W+1)'(MAX_RESOURCES)) : ID_W'(slot_sum);

    assign in_window  = (dseq >= retire_reg) && (dseq < issue_reg) &&
                        (diff < SEQ_WIDTH'(MAX_RESOURCES));
    assign push_ok    = 32'(free_top_reg) < MAX_RESOURCES;

    assign sts.fill_done  = (fill_cnt_reg == clamp);
    assign sts.exhausted  = (issue_reg >= total);
    assign sts.empty      = (free_top_reg == '0);
    assign sts.cmp_ok     = in_window && (CNT_W'(done_resource) < clamp) &&
                            (32'(done_resource) < MAX_RESOURCES) && !slot_done_reg[slot];
    assign sts.can_retire = (retire_reg < total) && slot_done_reg[rslot_reg];
    assign sts.more       = (burst_reg < BURST_W'(MAX_OUT - 1)) && (retire_inc < total) &&
                            slot_done_reg[rslot_inc];
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign stack_we = cmd.fill || (cmd.retire && push_ok);
    assign stack_wa = cmd.fill ? fill_cnt_reg[ID_W-1:0] : free_top_reg[ID_W-1:0];
    assign stack_wd = cmd.fill ? fill_cnt_reg[ID_W-1:0] : ID_W'(slot_rd_reg);
    assign slot_re  = cmd.slot_rd || (cmd.retire && sts.more);
    assign slot_ra  = cmd.slot_rd ? rslot_reg : rslot_inc;

    always_comb
    begin
        free_top_next   = free_top_reg;
        fill_cnt_next   = fill_cnt_reg;
        issue_next      = issue_reg;
        retire_next     = retire_reg;
        rslot_next      = rslot_reg;
        slot_done_next  = slot_done_reg;
        burst_next      = burst_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_res_next    = out_res_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;

        if (cmd.start)
        begin
            free_top_next  = '0;
            fill_cnt_next  = '0;
            issue_next     = '0;
            retire_next    = '0;
            rslot_next     = '0;
            slot_done_next = '0;
        end
        if (cmd.fill)
        begin
            fill_cnt_next = fill_cnt_reg + CNT_W'(1);
            free_top_next = free_top_reg + CNT_W'(1);
        end
        if (cmd.pop)
        begin
            free_top_next = top_m1;
        end
        if (cmd.mark)
        begin
            slot_done_next[slot] = 1'b1;
            burst_next           = '0;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.code;
            out_res_next    = '0;
            out_seq_next    = '0;
            out_last_next   = 1'b1;
            out_done_next   = (retire_reg >= total);
        end
        if (cmd.grant)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_GRANT;
            out_res_next    = 4'(stack_rd_reg);
            out_seq_next    = 32'(issue_reg);
            out_last_next   = 1'b1;
            out_done_next   = (retire_reg >= total);
            issue_next      = issue_reg + SEQ_WIDTH'(1);
        end
        if (cmd.retire)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_RETIRE;
            out_res_next    = slot_rd_reg;
            out_seq_next    = 32'(retire_reg);
            out_last_next   = !sts.more;
            out_done_next   = (retire_inc >= total);
            slot_done_next[rslot_reg] = 1'b0;
            retire_next     = retire_inc;
            rslot_next      = rslot_inc;
            burst_next      = burst_reg + BURST_W'(1);
            if (push_ok)
            begin
                free_top_next = free_top_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_top_reg  <= '0;
            fill_cnt_reg  <= '0;
            issue_reg     <= '0;
            retire_reg    <= '0;
            rslot_reg     <= '0;
            slot_done_reg <= '0;
            burst_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_top_reg  <= free_top_next;
            fill_cnt_reg  <= fill_cnt_next;
            issue_reg     <= issue_next;
            retire_reg    <= retire_next;
            rslot_reg     <= rslot_next;
            slot_done_reg <= slot_done_next;
            burst_reg     <= burst_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_res_reg    <= out_res_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
        out_done_reg   <= out_done_next;
    end

    // free stack: one write port, registered read for pop
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (cmd.pop)
        begin
            stack_rd_reg <= stack_mem[top_m1[ID_W-1:0]];
        end
    end

    // slot resource table: written on completion, read ahead during retirement
    always_ff @(posedge clk)
    begin
        if (cmd.mark)
        begin
            slot_mem[slot] <= done_resource;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_resource = out_res_reg;
    assign out_sequence = out_seq_reg;
    assign out_last     = out_last_reg;
    assign out_all_done = out_done_reg;

endmodule

FILE: hw/rtl/resource_reorder_retirer_top.sv
// Resource reorder retirer: in-order tag issue, in-order retirement.
// Flow: reject/wait/exhausted are answered straight from idle; a grant pops the free stack,
// then emits; a start fills the free stack, then reports; a completion marks its slot, checks
// the oldest slot (reporting none-ready if it is not done), reads it, then retires one per cycle
// while the output is not stalled. Only one request is handled at a time.
// Reset (rst_n low, async): counters, slot flags, FSM and output valid cleared.
module resource_reorder_retirer_top
    import rrr_pkg::*;
#(
    parameter int MAX_RESOURCES = 16,
    parameter int SEQ_WIDTH     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // done_resource[3:0], done_sequence[35:4], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // resource_id[3:0], sequence_id[35:4], all_done[36], pad
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] seq_total_reg, seq_total_next;
    logic [4:0]  res_count_reg, res_count_next;
    logic        cfg_wr;
    cmd_t        cmd;
    sts_t        sts;
    logic [3:0]  out_resource;
    logic [31:0] out_sequence;
    logic        out_all_done;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        seq_total_next = seq_total_reg;
        res_count_next = res_count_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_SEQ_TOTAL: seq_total_next = pwdata;
                REG_RES_COUNT: res_count_next = pwdata[4:0];
                default:       seq_total_next = seq_total_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SEQ_TOTAL: prdata = seq_total_reg;
            REG_RES_COUNT: prdata = {27'd0, res_count_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_total_reg <= 32'd0;
            res_count_reg <= 5'd16;
        end
        else
        begin
            seq_total_reg <= seq_total_next;
            res_count_reg <= res_count_next;
        end
    end

    rrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .mode     (s_tuser),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    rrr_dp #(
        .MAX_RESOURCES (MAX_RESOURCES),
        .SEQ_WIDTH     (SEQ_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .done_resource (s_tdata[3:0]),
        .done_sequence (s_tdata[35:4]),
        .seq_total     (seq_total_reg),
        .res_count     (res_count_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (m_tuser),
        .out_resource  (out_resource),
        .out_sequence  (out_sequence),
        .out_last      (m_tlast),
        .out_all_done  (out_all_done)
    );

    assign m_tdata = {3'd0, out_all_done, out_sequence, out_resource};

    // new request only taken when the result register can accept a result
    a_in_needs_out_space: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("request accepted while result register blocked");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != STAT_RETIRE) |-> m_tlast)
        else $error("single-result status without tlast");

    a_plain_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_WAIT || m_tuser == STAT_EXHAUSTED ||
                      m_tuser == STAT_NONE_READY || m_tuser == STAT_REJECTED ||
                      m_tuser == STAT_STARTED)) |-> (m_tdata[35:0] == 36'd0))
        else $error("nonzero id or sequence on a plain status");

endmodule
